>>> rtl/wmoc_pkg.sv
package wmoc_pkg;

	localparam int MAX_SEGMENT = 4096;
	localparam int COUNT_WIDTH = 16;
	localparam int POS_WIDTH   = $clog2(MAX_SEGMENT);
	localparam int LEN_WIDTH   = 13;
	localparam int MIN_SEGMENT = 4;
	localparam int MAJORITY    = 3;

	localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(MAX_SEGMENT);

	typedef enum logic {
		REG_FILTER = 1'b0,
		REG_LENGTH = 1'b1
	} reg_idx_t;

	function automatic logic majority5(input logic [4:0] votes);
		logic [2:0] n;
		n = 3'($countones(votes));
		return n >= 3'(MAJORITY);
	endfunction

endpackage

>>> rtl/window_majority_on_counter.sv
// Five-tap majority on-counter over column segments.
// Input channel (in_valid/in_ready) carries one neuron_on bit per item plus a
// last_item mark. Items are cut into segments of segment_length items, held to
// 4..4096; with filter_enable set a position counts when 3 of its 5-wide
// window are on, neighbors outside the segment counting as on. With the filter
// off each on bit counts. The saturating count is returned on the output
// channel (out_valid/out_ready, on_count) only for an item marked last_item.
// Throughput: one item per cycle unless stalled (see below); the window,
// position and counter update in the cycle an item is accepted.
// Latency: the result is valid the cycle after the last item is accepted,
// from a single output register. A stalled receiver holds the result there;
// while it waits in_ready stays low, so the input stalls until it is taken.
// Registers sit on the APB port: filter_enable at 0x0, segment_length at 0x4.
// Reset: filter on, segment length 4096, window, position and count cleared,
// no result pending.
module window_majority_on_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        neuron_on,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] on_count
);

	logic                                filter_q;
	logic [wmoc_pkg::LEN_WIDTH-1:0]      seg_len_q;
	logic [3:0]                          recent_q;
	logic [wmoc_pkg::POS_WIDTH-1:0]      pos_q;
	logic [wmoc_pkg::COUNT_WIDTH-1:0]    count_q;
	logic                                out_valid_q;
	logic [wmoc_pkg::COUNT_WIDTH-1:0]    on_count_q;

	logic                                accept;
	logic                                cfg_wr;
	wmoc_pkg::reg_idx_t                  reg_idx;
	logic [wmoc_pkg::POS_WIDTH-1:0]      last_pos;
	logic                                seg_end;
	logic [4:0]                          w;
	logic [6:0]                          e;
	logic                                dec_a, dec_b, dec_c;
	logic [1:0]                          amt;
	logic [wmoc_pkg::COUNT_WIDTH:0]      sum;
	logic [wmoc_pkg::COUNT_WIDTH-1:0]    count_nx;

	assign pready    = 1'b1;
	assign reg_idx   = wmoc_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr    = psel & penable & pwrite;
	assign in_ready  = ~out_valid_q | out_ready;
	assign accept    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign on_count  = 16'(on_count_q);

	always_comb begin
		case (reg_idx)
			wmoc_pkg::REG_FILTER: prdata = {31'd0, filter_q};
			wmoc_pkg::REG_LENGTH: prdata = {{(32 - wmoc_pkg::LEN_WIDTH){1'b0}}, seg_len_q};
			default:              prdata = '0;
		endcase
	end

	// index of the final position in force
	always_comb begin
		if (seg_len_q < wmoc_pkg::LEN_WIDTH'(wmoc_pkg::MIN_SEGMENT))
			last_pos = wmoc_pkg::POS_WIDTH'(wmoc_pkg::MIN_SEGMENT - 1);
		else if (seg_len_q > wmoc_pkg::LEN_WIDTH'(wmoc_pkg::MAX_SEGMENT))
			last_pos = wmoc_pkg::POS_WIDTH'(wmoc_pkg::MAX_SEGMENT - 1);
		else
			last_pos = wmoc_pkg::POS_WIDTH'(seg_len_q - 1'b1);
	end

	assign seg_end = pos_q >= last_pos;
	assign w       = {recent_q, neuron_on};

	// e[k+2]: vote of the position k steps back from the current one
	always_comb begin
		e[0] = seg_end | (pos_q == last_pos - 1'b1);
		e[1] = seg_end;
		e[2] = w[0];
		for (int k = 1; k <= 4; k++)
			e[k+2] = (pos_q < wmoc_pkg::POS_WIDTH'(k)) ? 1'b1 : w[k];
	end

	always_comb begin
		dec_a = (pos_q >= wmoc_pkg::POS_WIDTH'(2)) && wmoc_pkg::majority5(e[6:2]);
		dec_b = (seg_end | last_item) && (pos_q >= wmoc_pkg::POS_WIDTH'(1))
			&& wmoc_pkg::majority5(e[5:1]);
		dec_c = (seg_end | last_item) && wmoc_pkg::majority5(e[4:0]);
		if (filter_q)
			amt = 2'(dec_a) + 2'(dec_b) + 2'(dec_c);
		else
			amt = {1'b0, neuron_on};
		sum = {1'b0, count_q} + (wmoc_pkg::COUNT_WIDTH + 1)'(amt);
		if (sum[wmoc_pkg::COUNT_WIDTH])
			count_nx = '1;
		else
			count_nx = sum[wmoc_pkg::COUNT_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q    <= 1'b1;
			seg_len_q   <= wmoc_pkg::LEN_RESET;
			recent_q    <= '0;
			pos_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (reg_idx)
					wmoc_pkg::REG_FILTER: filter_q  <= pwdata[0];
					wmoc_pkg::REG_LENGTH: seg_len_q <= pwdata[wmoc_pkg::LEN_WIDTH-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (last_item || seg_end) begin
					recent_q <= '0;
					pos_q    <= '0;
				end else begin
					recent_q <= w[3:0];
					pos_q    <= pos_q + 1'b1;
				end
				count_q <= last_item ? '0 : count_nx;
			end
			if (accept && last_item)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_item)
			on_count_q <= count_nx;
	end

endmodule
